// ===== hdl/c2s_pkg.sv =====
package c2s_pkg;

  // Field types of one calendar reading
  typedef logic [5:0] second_t;
  typedef logic [5:0] minute_t;
  typedef logic [4:0] hour_t;
  typedef logic [4:0] day_t;
  typedef logic [3:0] month_t;
  typedef logic [6:0] year_t;

  // Internal and result types
  typedef logic [7:0]  century_t;
  typedef logic [15:0] days_t;
  typedef logic [16:0] tod_t;
  typedef logic [8:0]  month_days_t;
  typedef logic [39:0] total_t;

  // Fixed constants (century is 36524.219 days in seconds, truncated)
  localparam logic [31:0] CenturySeconds   = 32'd3155692521;
  localparam logic [16:0] SecondsPerDay    = 17'd86400;
  localparam logic [11:0] SecondsPerHour   = 12'd3600;
  localparam logic [5:0]  SecondsPerMinute = 6'd60;
  localparam logic [8:0]  DaysNormalYear   = 9'd365;
  localparam year_t       LastYearOfCentury = 7'd99;
  localparam month_t      MonthsPerYear    = 4'd12;

  // Registered reading between capture and sum stages
  typedef struct packed {
    century_t century;
    days_t    days;
    tod_t     tod;
  } stage_t;

  // Days before a month, indexed by number of whole months (0..12)
  function automatic month_days_t days_before_month(input month_t whole, input logic leap);
    month_days_t base;
    base = 9'd0;
    case (whole)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    // leap day counts once February is complete
    if (leap && (whole >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== hdl/c2s_in_if.sv =====
interface c2s_in_if;
  logic                valid;
  logic                ready;
  c2s_pkg::second_t    second_of_minute;
  c2s_pkg::minute_t    minute_of_hour;
  c2s_pkg::hour_t      hour_of_day;
  c2s_pkg::day_t       day_of_month;
  c2s_pkg::month_t     month_of_year;
  c2s_pkg::year_t      year_in_century;

  modport source (
    output valid, second_of_minute, minute_of_hour, hour_of_day,
           day_of_month, month_of_year, year_in_century,
    input  ready
  );
  modport sink (
    input  valid, second_of_minute, minute_of_hour, hour_of_day,
           day_of_month, month_of_year, year_in_century,
    output ready
  );
endinterface

// ===== hdl/c2s_out_if.sv =====
interface c2s_out_if;
  logic            valid;
  logic            ready;
  c2s_pkg::total_t total_seconds;

  modport source (output valid, total_seconds, input ready);
  modport sink (input valid, total_seconds, output ready);
endinterface

// ===== hdl/calendar_to_seconds_count.sv =====
// Channel  Role    Payload
// reading  sink    second_of_minute, minute_of_hour, hour_of_day,
//                  day_of_month, month_of_year, year_in_century
// result   source  total_seconds (40 bits)
//
// One transaction per cycle sustained while result is not stalled; a reading
// passes the capture register, then the result register, before its result appears.
// The capture stage sets the day count, time of day and century roll; the
// result stage forms the two constant products and the sum.
// A stall on result holds both registers and drops reading.ready once full.
// Synchronous reset clears the valid flags, last year seen and century count.
module calendar_to_seconds_count (
  input  logic      clk,
  input  logic      rst,
  c2s_in_if.sink    reading,
  c2s_out_if.source result
);
  import c2s_pkg::*;

  logic   stage_valid;
  logic   stage_ready;
  stage_t stage;

  c2s_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .reading     (reading),
    .stage_ready (stage_ready),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  c2s_sum u_sum (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_ready (stage_ready),
    .result      (result)
  );

endmodule

// ===== hdl/c2s_capture.sv =====
module c2s_capture (
  input  logic            clk,
  input  logic            rst,
  c2s_in_if.sink          reading,
  input  logic            stage_ready,
  output logic            stage_valid,
  output c2s_pkg::stage_t stage
);
  import c2s_pkg::*;

  year_t    last_year;
  century_t century;
  century_t century_next;
  logic     accept;
  logic     leap;
  month_t   whole_months;
  days_t    year_ext;
  days_t    year_days;
  days_t    days;
  tod_t     tod;

  // Stage register frees when empty or when its transaction moves on
  assign reading.ready = !stage_valid || stage_ready;
  assign accept        = reading.valid && reading.ready;

  // Century roll: 99 followed by 0
  always_comb begin
    century_next = century;
    if ((last_year == LastYearOfCentury) && (reading.year_in_century == 7'd0)) begin
      century_next = century + 8'd1;
    end
  end

  // Day count: whole years, whole months, then the day as given
  always_comb begin
    leap = (reading.year_in_century[1:0] == 2'd0);
    if (reading.month_of_year == 4'd0) begin
      whole_months = 4'd0;
    end else if (reading.month_of_year > MonthsPerYear) begin
      whole_months = MonthsPerYear;
    end else begin
      whole_months = reading.month_of_year - 4'd1;
    end
    year_ext  = {9'd0, reading.year_in_century};
    year_days = year_ext * {7'd0, DaysNormalYear} + ((year_ext + 16'd3) >> 2);
    days      = year_days + {7'd0, days_before_month(whole_months, leap)}
              + {11'd0, reading.day_of_month};
  end

  // Time of day in seconds
  always_comb begin
    tod = {12'd0, reading.hour_of_day} * {5'd0, SecondsPerHour}
        + {11'd0, reading.minute_of_hour} * {11'd0, SecondsPerMinute}
        + {11'd0, reading.second_of_minute};
  end

  // Control and century state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      last_year   <= '0;
      century     <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
        last_year   <= reading.year_in_century;
        century     <= century_next;
      end else if (stage_ready) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.century <= century_next;
      stage.days    <= days;
      stage.tod     <= tod;
    end
  end

endmodule

// ===== hdl/c2s_sum.sv =====
module c2s_sum (
  input  logic            clk,
  input  logic            rst,
  input  logic            stage_valid,
  input  c2s_pkg::stage_t stage,
  output logic            stage_ready,
  c2s_out_if.source       result
);
  import c2s_pkg::*;

  total_t century_part;
  total_t day_part;
  total_t total;
  logic   load;

  // Result register takes a transaction when empty or being drained
  assign stage_ready = !result.valid || result.ready;
  assign load        = stage_valid && stage_ready;

  // Two constant products in parallel, then the sum
  always_comb begin
    century_part = {32'd0, stage.century} * {8'd0, CenturySeconds};
    day_part     = {24'd0, stage.days} * {23'd0, SecondsPerDay};
    total        = century_part + day_part + {23'd0, stage.tod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.total_seconds <= total;
    end
  end

endmodule
